FILE: src/plob_pkg.sv
// Shared constants, codes and types of the price-level order book.
package plob_pkg;

   // Default geometry of the book
   localparam int LEVELS_DEF     = 32;
   localparam int PRICE_BITS_DEF = 32;
   localparam int QTY_BITS_DEF   = 32;

   // Fixed port field widths
   localparam int FIELD_W     = 32;
   localparam int CFG_W       = 6;
   localparam int DEPTH_W     = 37;
   localparam int COUNT_OUT_W = 6;
   localparam int WIDE_W      = 33;

   localparam logic [CFG_W-1:0] DEPTH_RESET = 6'd5;

   localparam logic CMD_CLEAR = 1'b1;
   localparam logic SIDE_ASK  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_ZERO_PRICE,
      STATUS_FULL
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_WRITE
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic upd;        // apply an update word to this side
      logic clr;        // empty this side
      logic sum_start;  // restart the depth accumulator
      logic sum_step;   // accumulate one more level
   } side_ctl_type;

endpackage

FILE: src/plob_cell.sv
// One price level cell: holds a price and quantity, shifts with its neighbors.
module plob_cell #(
   parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF,
   parameter bit ASK        = 1'b0
) (
   input  logic                    clock,
   input  plob_pkg::cell_op_type   op,
   input  logic                    occ,
   input  logic [PRICE_BITS-1:0]   key_price,
   input  logic [QTY_BITS-1:0]     key_qty,
   input  logic                    prev_ins,
   input  logic [PRICE_BITS-1:0]   prev_price,
   input  logic [QTY_BITS-1:0]     prev_qty,
   input  logic [PRICE_BITS-1:0]   next_price,
   input  logic [QTY_BITS-1:0]     next_qty,
   output logic [PRICE_BITS-1:0]   price,
   output logic [QTY_BITS-1:0]     qty,
   output logic                    eq,
   output logic                    ins
);

   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [QTY_BITS-1:0]   qty_ff, qty_in;
   logic                  gb;

   // gb: new key sorts ahead of this level
   assign eq  = occ && (price_ff == key_price);
   assign gb  = occ && (ASK ? (key_price < price_ff) : (key_price > price_ff));
   assign ins = gb || !occ;

   always_comb begin
      price_in = price_ff;
      qty_in   = qty_ff;
      case (op)
         plob_pkg::OP_INSERT: begin
            if (prev_ins) begin
               price_in = prev_price;
               qty_in   = prev_qty;
            end else if (ins) begin
               price_in = key_price;
               qty_in   = key_qty;
            end
         end
         plob_pkg::OP_REMOVE: begin
            if (gb || eq) begin
               price_in = next_price;
               qty_in   = next_qty;
            end
         end
         plob_pkg::OP_WRITE: begin
            if (eq) qty_in = key_qty;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   assign price = price_ff;
   assign qty   = qty_ff;

endmodule

FILE: src/plob_side.sv
// One side of the book: a sorted row of level cells, level count and depth sum.
module plob_side #(
   parameter int LEVELS     = plob_pkg::LEVELS_DEF,
   parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF,
   parameter bit ASK        = 1'b0,
   localparam int CNT_W     = $clog2(LEVELS + 1),
   localparam int IDX_W     = $clog2(LEVELS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  plob_pkg::side_ctl_type         ctl,
   input  logic [PRICE_BITS-1:0]          key_price,
   input  logic [QTY_BITS-1:0]            key_qty,
   input  logic [plob_pkg::CFG_W-1:0]     depth_levels,
   output logic [CNT_W-1:0]               count,
   output logic [PRICE_BITS-1:0]          top_price,
   output logic                           drop,
   output logic [plob_pkg::DEPTH_W-1:0]   depth_sum,
   output logic                           sum_done
);

   localparam int CMP_W = (CNT_W > plob_pkg::CFG_W) ? CNT_W : plob_pkg::CFG_W;
   localparam int QX_W  = (QTY_BITS > plob_pkg::DEPTH_W) ? QTY_BITS : plob_pkg::DEPTH_W;

   logic [PRICE_BITS-1:0]      price_a      [LEVELS];
   logic [QTY_BITS-1:0]        qty_a        [LEVELS];
   logic [PRICE_BITS-1:0]      prev_price_a [LEVELS];
   logic [QTY_BITS-1:0]        prev_qty_a   [LEVELS];
   logic [PRICE_BITS-1:0]      next_price_a [LEVELS];
   logic [QTY_BITS-1:0]        next_qty_a   [LEVELS];
   logic [LEVELS-1:0]          eq_v, ins_v, occ_v, prev_ins_v;

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CMP_W-1:0]           k_ff, lim;
   logic [plob_pkg::DEPTH_W-1:0] acc_ff;
   logic [QX_W-1:0]            q_ext;
   plob_pkg::cell_op_type      op;
   logic                       any_match, qzero, full;

   genvar i;
   generate
      for (i = 0; i < LEVELS; i++) begin : g_cell
         assign occ_v[i] = CNT_W'(i) < count_ff;

         if (i == 0) begin : g_first
            assign prev_ins_v[i]   = 1'b0;
            assign prev_price_a[i] = price_a[i];
            assign prev_qty_a[i]   = qty_a[i];
         end else begin : g_mid
            assign prev_ins_v[i]   = ins_v[i-1];
            assign prev_price_a[i] = price_a[i-1];
            assign prev_qty_a[i]   = qty_a[i-1];
         end

         if (i == LEVELS - 1) begin : g_last
            assign next_price_a[i] = price_a[i];
            assign next_qty_a[i]   = qty_a[i];
         end else begin : g_next
            assign next_price_a[i] = price_a[i+1];
            assign next_qty_a[i]   = qty_a[i+1];
         end

         plob_cell #(
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS),
            .ASK        (ASK)
         ) u_cell (
            .clock      (clock),
            .op         (op),
            .occ        (occ_v[i]),
            .key_price  (key_price),
            .key_qty    (key_qty),
            .prev_ins   (prev_ins_v[i]),
            .prev_price (prev_price_a[i]),
            .prev_qty   (prev_qty_a[i]),
            .next_price (next_price_a[i]),
            .next_qty   (next_qty_a[i]),
            .price      (price_a[i]),
            .qty        (qty_a[i]),
            .eq         (eq_v[i]),
            .ins        (ins_v[i])
         );
      end
   endgenerate

   assign any_match = |eq_v;
   assign qzero     = (key_qty == '0);
   assign full      = (count_ff == CNT_W'(LEVELS));

   // Pick the row operation and next count
   always_comb begin
      op       = plob_pkg::OP_HOLD;
      drop     = 1'b0;
      count_in = count_ff;
      if (ctl.clr) begin
         count_in = '0;
      end else if (ctl.upd) begin
         if (qzero) begin
            if (any_match) begin
               op       = plob_pkg::OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end else if (any_match) begin
            op = plob_pkg::OP_WRITE;
         end else if (full) begin
            drop = 1'b1;
         end else begin
            op       = plob_pkg::OP_INSERT;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Depth sum walks the best levels one per cycle
   assign lim      = (CMP_W'(depth_levels) < CMP_W'(count_ff)) ?
                     CMP_W'(depth_levels) : CMP_W'(count_ff);
   assign sum_done = (k_ff >= lim);
   assign q_ext    = QX_W'(qty_a[k_ff[IDX_W-1:0]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         count_ff <= count_in;
         if (ctl.sum_start) begin
            k_ff <= '0;
         end else if (ctl.sum_step && !sum_done) begin
            k_ff <= k_ff + CMP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_start) begin
         acc_ff <= '0;
      end else if (ctl.sum_step && !sum_done) begin
         acc_ff <= acc_ff + q_ext[plob_pkg::DEPTH_W-1:0];
      end
   end

   assign count     = count_ff;
   assign top_price = price_a[0];
   assign depth_sum = acc_ff;

endmodule

FILE: src/price_level_order_book_unit.sv
// Top level of the price-level order book: sequencing, result register, config.
// Sequence: a word is accepted in ST_IDLE; in ST_SUM each side's depth adder walks min(depth_levels,
//   levels held after the update) levels, then the result is loaded into the output register.
// The next word is taken only after that load; the depth adder walks one level a cycle.
// A finished result may wait in the output register while the next word is taken.
// Reset (synchronous, active high): both sides empty, depth_levels = 5, no result, no word taken.
module price_level_order_book_unit #(
   parameter int LEVELS     = plob_pkg::LEVELS_DEF,
   parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // update / clear words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic                                  req_side,
   input  logic [plob_pkg::FIELD_W-1:0]          req_price,
   input  logic [plob_pkg::FIELD_W-1:0]          req_quantity,
   // top-of-book result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [plob_pkg::FIELD_W-1:0]          rsp_best_bid,
   output logic                                  rsp_bid_valid,
   output logic [plob_pkg::FIELD_W-1:0]          rsp_best_ask,
   output logic                                  rsp_ask_valid,
   output logic signed [plob_pkg::WIDE_W-1:0]    rsp_spread,
   output logic [plob_pkg::WIDE_W-1:0]           rsp_mid_twice,
   output logic [plob_pkg::DEPTH_W-1:0]          rsp_bid_depth,
   output logic [plob_pkg::DEPTH_W-1:0]          rsp_ask_depth,
   output logic [plob_pkg::COUNT_OUT_W-1:0]      rsp_bid_count,
   output logic [plob_pkg::COUNT_OUT_W-1:0]      rsp_ask_count,
   // depth_levels register
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [plob_pkg::CFG_W-1:0]            csr_depth_levels
);

   localparam int CNT_W = $clog2(LEVELS + 1);
   // widths used to carry values through zero-extend or truncate
   localparam int PIN_W = (PRICE_BITS > plob_pkg::FIELD_W) ? PRICE_BITS : plob_pkg::FIELD_W;
   localparam int QIN_W = (QTY_BITS > plob_pkg::FIELD_W) ? QTY_BITS : plob_pkg::FIELD_W;
   localparam int PX_W  = (PRICE_BITS > plob_pkg::WIDE_W) ? PRICE_BITS : plob_pkg::WIDE_W;
   localparam int CX_W  = (CNT_W > plob_pkg::COUNT_OUT_W) ? CNT_W : plob_pkg::COUNT_OUT_W;

   plob_pkg::state_type      state_ff, state_in;
   plob_pkg::status_type     status_ff, status_in;
   plob_pkg::side_ctl_type   bid_ctl, ask_ctl;

   logic [plob_pkg::CFG_W-1:0] depth_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [PIN_W-1:0]           price_ext;
   logic [QIN_W-1:0]           qty_ext;
   logic [PRICE_BITS-1:0]      key_price;
   logic [QTY_BITS-1:0]        key_qty;
   logic                       accept, is_clear, is_upd, load;

   logic [CNT_W-1:0]           bid_cnt, ask_cnt;
   logic [PRICE_BITS-1:0]      bid_top, ask_top;
   logic                       bid_drop, ask_drop, bid_done, ask_done;
   logic [plob_pkg::DEPTH_W-1:0] bid_sum, ask_sum;

   logic [PX_W-1:0]            bb_x, ba_x;
   logic [plob_pkg::WIDE_W-1:0] bb_w, ba_w;
   logic [CX_W-1:0]            bc_x, ac_x;
   logic                       bv, av;

   // output register fields
   logic [1:0]                          status_q_ff;
   logic [plob_pkg::FIELD_W-1:0]        best_bid_ff, best_ask_ff;
   logic                                bid_valid_ff, ask_valid_ff;
   logic [plob_pkg::WIDE_W-1:0]         spread_ff, mid_ff;
   logic [plob_pkg::DEPTH_W-1:0]        bid_depth_ff, ask_depth_ff;
   logic [plob_pkg::COUNT_OUT_W-1:0]    bid_count_ff, ask_count_ff;

   // Input handshake: one word in flight at a time, nothing taken in reset
   assign req_stall = reset || (state_ff != plob_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !reset;

   // Fit the port fields to the book's internal widths
   assign price_ext = PIN_W'(req_price);
   assign qty_ext   = QIN_W'(req_quantity);
   assign key_price = price_ext[PRICE_BITS-1:0];
   assign key_qty   = qty_ext[QTY_BITS-1:0];

   assign is_clear = (req_cmd == plob_pkg::CMD_CLEAR);
   // zero price never reaches the cells
   assign is_upd   = !is_clear && (key_price != '0);

   always_comb begin
      bid_ctl.upd       = accept && is_upd && (req_side != plob_pkg::SIDE_ASK);
      bid_ctl.clr       = accept && is_clear;
      bid_ctl.sum_start = accept;
      bid_ctl.sum_step  = (state_ff == plob_pkg::ST_SUM);
      ask_ctl.upd       = accept && is_upd && (req_side == plob_pkg::SIDE_ASK);
      ask_ctl.clr       = bid_ctl.clr;
      ask_ctl.sum_start = accept;
      ask_ctl.sum_step  = bid_ctl.sum_step;
   end

   plob_side #(
      .LEVELS     (LEVELS),
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS),
      .ASK        (1'b0)
   ) u_bid (
      .clock        (clock),
      .reset        (reset),
      .ctl          (bid_ctl),
      .key_price    (key_price),
      .key_qty      (key_qty),
      .depth_levels (depth_ff),
      .count        (bid_cnt),
      .top_price    (bid_top),
      .drop         (bid_drop),
      .depth_sum    (bid_sum),
      .sum_done     (bid_done)
   );

   plob_side #(
      .LEVELS     (LEVELS),
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS),
      .ASK        (1'b1)
   ) u_ask (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ask_ctl),
      .key_price    (key_price),
      .key_qty      (key_qty),
      .depth_levels (depth_ff),
      .count        (ask_cnt),
      .top_price    (ask_top),
      .drop         (ask_drop),
      .depth_sum    (ask_sum),
      .sum_done     (ask_done)
   );

   // Status of the accepted word, decided at the update edge
   always_comb begin
      status_in = status_ff;
      if (accept) begin
         if (is_clear)
            status_in = plob_pkg::STATUS_OK;
         else if (key_price == '0)
            status_in = plob_pkg::STATUS_ZERO_PRICE;
         else if (bid_drop || ask_drop)
            status_in = plob_pkg::STATUS_FULL;
         else
            status_in = plob_pkg::STATUS_OK;
      end
   end

   // Result goes out once both depth sums are done and the output slot is free
   assign load = (state_ff == plob_pkg::ST_SUM) && bid_done && ask_done &&
                 (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plob_pkg::ST_IDLE: if (accept) state_in = plob_pkg::ST_SUM;
         plob_pkg::ST_SUM:  if (load)   state_in = plob_pkg::ST_IDLE;
         default:           state_in = plob_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plob_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= plob_pkg::DEPTH_RESET;
         status_ff    <= plob_pkg::STATUS_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         if (csr_valid && csr_ready) depth_ff <= csr_depth_levels;
      end
   end

   // Top of book, 33-bit spread and mid wrap like the field widths
   assign bv   = (bid_cnt != '0);
   assign av   = (ask_cnt != '0);
   assign bb_x = bv ? PX_W'(bid_top) : '0;
   assign ba_x = av ? PX_W'(ask_top) : '0;
   assign bb_w = bb_x[plob_pkg::WIDE_W-1:0];
   assign ba_w = ba_x[plob_pkg::WIDE_W-1:0];
   assign bc_x = CX_W'(bid_cnt);
   assign ac_x = CX_W'(ask_cnt);

   always_ff @(posedge clock) begin
      if (load) begin
         status_q_ff  <= status_ff;
         best_bid_ff  <= bb_x[plob_pkg::FIELD_W-1:0];
         best_ask_ff  <= ba_x[plob_pkg::FIELD_W-1:0];
         bid_valid_ff <= bv;
         ask_valid_ff <= av;
         spread_ff    <= (bv && av) ? (ba_w - bb_w) : '0;
         mid_ff       <= (bv && av) ? (ba_w + bb_w) : '0;
         bid_depth_ff <= bid_sum;
         ask_depth_ff <= ask_sum;
         bid_count_ff <= bc_x[plob_pkg::COUNT_OUT_W-1:0];
         ask_count_ff <= ac_x[plob_pkg::COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_q_ff;
   assign rsp_best_bid  = best_bid_ff;
   assign rsp_best_ask  = best_ask_ff;
   assign rsp_bid_valid = bid_valid_ff;
   assign rsp_ask_valid = ask_valid_ff;
   assign rsp_spread    = $signed(spread_ff);
   assign rsp_mid_twice = mid_ff;
   assign rsp_bid_depth = bid_depth_ff;
   assign rsp_ask_depth = ask_depth_ff;
   assign rsp_bid_count = bid_count_ff;
   assign rsp_ask_count = ask_count_ff;

endmodule

FILE: src/plob_checker.sv
// Port-level checks on the order book top level, bound to it.
module plob_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [plob_pkg::FIELD_W-1:0]          rsp_best_bid,
   input logic                                  rsp_bid_valid,
   input logic                                  rsp_ask_valid,
   input logic signed [plob_pkg::WIDE_W-1:0]    rsp_spread,
   input logic [plob_pkg::WIDE_W-1:0]           rsp_mid_twice,
   input logic [plob_pkg::DEPTH_W-1:0]          rsp_bid_depth,
   input logic [plob_pkg::COUNT_OUT_W-1:0]      rsp_bid_count
);

   // a held result word stays valid and keeps its best bid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_bid))
      else $error("result word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before result was built");

   a_bid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bid_valid == (rsp_bid_count != '0)))
      else $error("bid valid flag disagrees with bid count");

   a_empty_bid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bid_valid |-> (rsp_best_bid == '0) && (rsp_bid_depth == '0))
      else $error("empty bid side reports price or depth");

   a_one_sided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_bid_valid && rsp_ask_valid) |->
         (rsp_spread == '0) && (rsp_mid_twice == '0))
      else $error("spread or mid nonzero with a side empty");

endmodule

bind price_level_order_book_unit plob_checker u_plob_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_best_bid  (rsp_best_bid),
   .rsp_bid_valid (rsp_bid_valid),
   .rsp_ask_valid (rsp_ask_valid),
   .rsp_spread    (rsp_spread),
   .rsp_mid_twice (rsp_mid_twice),
   .rsp_bid_depth (rsp_bid_depth),
   .rsp_bid_count (rsp_bid_count)
);

FILE: test/tb.sv
// Self-checking testbench for price_level_order_book_unit: predicted top of book per word.
`timescale 1ns / 100ps

module tb;

   // Widths taken from the package
   localparam int FIELD_W     = plob_pkg::FIELD_W;
   localparam int WIDE_W      = plob_pkg::WIDE_W;
   localparam int DEPTH_W     = plob_pkg::DEPTH_W;
   localparam int COUNT_OUT_W = plob_pkg::COUNT_OUT_W;
   localparam int CFG_W       = plob_pkg::CFG_W;

   // Opcode and side names built from the package codes
   localparam logic CMD_UPDATE = ~plob_pkg::CMD_CLEAR;
   localparam logic SIDE_BID   = ~plob_pkg::SIDE_ASK;

   localparam int PERIOD       = 8;
   localparam int BOOK_LEVELS  = plob_pkg::LEVELS_DEF;
   localparam int RANDOM_WORDS = 980;
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   // The quiet limit covers the slowest word plus sender gaps and stalls; the hold-off dominates.
   localparam int QUIET_LIMIT  = 4000;
   localparam int MAX_SHOWN    = 40;     // mismatch lines printed, all are counted
   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

   // One top-of-book result word, as seen on the rsp_ ports
   typedef struct {
      logic [1:0]             status;
      logic [FIELD_W-1:0]     best_bid;
      logic                   bid_valid;
      logic [FIELD_W-1:0]     best_ask;
      logic                   ask_valid;
      logic [WIDE_W-1:0]      spread;
      logic [WIDE_W-1:0]      mid_twice;
      logic [DEPTH_W-1:0]     bid_depth;
      logic [DEPTH_W-1:0]     ask_depth;
      logic [COUNT_OUT_W-1:0] bid_count;
      logic [COUNT_OUT_W-1:0] ask_count;
   } top_word_type;

   // Book predictor plus the queue of top-of-book words still owed by the block.
   // Side index 0 is the bid table (descending), 1 the ask table (ascending).
   class book_board;
      logic [FIELD_W-1:0] level_px  [2][BOOK_LEVELS];
      logic [FIELD_W-1:0] level_qty [2][BOOK_LEVELS];
      int                 held [2];
      logic [CFG_W-1:0]   depth_levels;
      top_word_type       top_expected [$];
      int errors, checked, clears, rejects, drops, deepest;

      function new();
         held[0] = 0;
         held[1] = 0;
         depth_levels = plob_pkg::DEPTH_RESET;
         errors = 0;
         checked = 0;
         clears = 0;
         rejects = 0;
         drops = 0;
         deepest = 0;
      endfunction

      task report(string msg);
         if (errors < MAX_SHOWN) $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      // Apply one level update to a side; returns the status the block should give
      function plob_pkg::status_type apply_level(int s, logic [FIELD_W-1:0] p,
                                                 logic [FIELD_W-1:0] q);
         int n, i, k, pos;
         n = held[s];
         i = 0;
         while (i < n && level_px[s][i] != p) i++;
         if (q == 0) begin
            // remove if held, silently ignore otherwise
            if (i < n) begin
               for (k = i; k < n - 1; k++) begin
                  level_px[s][k]  = level_px[s][k+1];
                  level_qty[s][k] = level_qty[s][k+1];
               end
               held[s] = n - 1;
            end
            return plob_pkg::STATUS_OK;
         end
         if (i < n) begin
            level_qty[s][i] = q;
            return plob_pkg::STATUS_OK;
         end
         if (n >= BOOK_LEVELS) return plob_pkg::STATUS_FULL;
         pos = n;
         for (k = 0; k < n; k++) begin
            if (pos == n && ((s == plob_pkg::SIDE_ASK) ? (p < level_px[s][k]) :
                                                         (p > level_px[s][k])))
               pos = k;
         end
         for (k = n; k > pos; k--) begin
            level_px[s][k]  = level_px[s][k-1];
            level_qty[s][k] = level_qty[s][k-1];
         end
         level_px[s][pos]  = p;
         level_qty[s][pos] = q;
         held[s] = n + 1;
         return plob_pkg::STATUS_OK;
      endfunction

      function logic [DEPTH_W-1:0] side_depth(int s);
         logic [DEPTH_W-1:0] sum;
         int k;
         sum = '0;
         for (k = 0; k < held[s] && k < depth_levels; k++)
            sum = sum + DEPTH_W'(level_qty[s][k]);
         return sum;
      endfunction

      // An update or clear word was taken: predict the result it owes
      task note_word(logic cmd, logic side, logic [FIELD_W-1:0] price,
                     logic [FIELD_W-1:0] qty);
         top_word_type         w;
         plob_pkg::status_type st;
         st = plob_pkg::STATUS_OK;
         if (cmd == plob_pkg::CMD_CLEAR) begin
            held[0] = 0;
            held[1] = 0;
            clears++;
         end else if (price == 0) begin
            st = plob_pkg::STATUS_ZERO_PRICE;
            rejects++;
         end else begin
            st = apply_level(int'(side), price, qty);
            if (st == plob_pkg::STATUS_FULL) drops++;
         end
         w.status    = st;
         w.bid_valid = held[0] != 0;
         w.ask_valid = held[1] != 0;
         w.best_bid  = w.bid_valid ? level_px[0][0] : '0;
         w.best_ask  = w.ask_valid ? level_px[1][0] : '0;
         if (w.bid_valid && w.ask_valid) begin
            w.spread    = {1'b0, w.best_ask} - {1'b0, w.best_bid};
            w.mid_twice = {1'b0, w.best_ask} + {1'b0, w.best_bid};
         end else begin
            w.spread    = '0;
            w.mid_twice = '0;
         end
         w.bid_depth = side_depth(0);
         w.ask_depth = side_depth(1);
         w.bid_count = COUNT_OUT_W'(held[0]);
         w.ask_count = COUNT_OUT_W'(held[1]);
         if (held[0] > deepest) deepest = held[0];
         if (held[1] > deepest) deepest = held[1];
         top_expected.insert(top_expected.size(), w);
      endtask

      task compare_field(string name, logic [DEPTH_W-1:0] got, logic [DEPTH_W-1:0] want);
         if (got !== want)
            report($sformatf("word %0d: %s is %0h, expected %0h", checked, name, got, want));
      endtask

      task check_word(top_word_type got);
         top_word_type want;
         if (top_expected.size() == 0) begin
            report($sformatf("result word with nothing expected (status %0d)", got.status));
            return;
         end
         want = top_expected.pop_front();
         checked++;
         compare_field("status",    DEPTH_W'(got.status),    DEPTH_W'(want.status));
         compare_field("best_bid",  DEPTH_W'(got.best_bid),  DEPTH_W'(want.best_bid));
         compare_field("bid_valid", DEPTH_W'(got.bid_valid), DEPTH_W'(want.bid_valid));
         compare_field("best_ask",  DEPTH_W'(got.best_ask),  DEPTH_W'(want.best_ask));
         compare_field("ask_valid", DEPTH_W'(got.ask_valid), DEPTH_W'(want.ask_valid));
         compare_field("spread",    DEPTH_W'(got.spread),    DEPTH_W'(want.spread));
         compare_field("mid_twice", DEPTH_W'(got.mid_twice), DEPTH_W'(want.mid_twice));
         compare_field("bid_depth", got.bid_depth,           want.bid_depth);
         compare_field("ask_depth", got.ask_depth,           want.ask_depth);
         compare_field("bid_count", DEPTH_W'(got.bid_count), DEPTH_W'(want.bid_count));
         compare_field("ask_count", DEPTH_W'(got.ask_count), DEPTH_W'(want.ask_count));
      endtask

      task finish_check();
         if (top_expected.size() != 0)
            report($sformatf("%0d expected words never came out", top_expected.size()));
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = 1'b0;
   logic                     req_side = 1'b0;
   logic [FIELD_W-1:0]       req_price = '0;
   logic [FIELD_W-1:0]       req_quantity = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [FIELD_W-1:0]       rsp_best_bid;
   logic                     rsp_bid_valid;
   logic [FIELD_W-1:0]       rsp_best_ask;
   logic                     rsp_ask_valid;
   logic signed [WIDE_W-1:0] rsp_spread;
   logic [WIDE_W-1:0]        rsp_mid_twice;
   logic [DEPTH_W-1:0]       rsp_bid_depth;
   logic [DEPTH_W-1:0]       rsp_ask_depth;
   logic [COUNT_OUT_W-1:0]   rsp_bid_count;
   logic [COUNT_OUT_W-1:0]   rsp_ask_count;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CFG_W-1:0]         csr_depth_levels = '0;

   always #(PERIOD / 2) clock = ~clock;

   price_level_order_book_unit dut (.*);

   book_board board = new();

   // knobs shared between the stimulus thread and the receiver
   bit tx_idle = 1'b0;       // sender inserts random gaps
   bit rx_idle = 1'b0;       // receiver inserts random stall bursts
   int rx_hold = 0;          // nonzero: receiver holds off this many cycles
   int words_sent = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   // ---------------------------------------------------------------------------
   // Result side: stall generator and checker
   // ---------------------------------------------------------------------------
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (rx_hold != 0) begin
            // long hold-off; the block fills and stalls its request side
            rsp_stall <= 1'b1;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
            rsp_stall <= 1'b0;
         end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Outputs are sampled right after the edge, i.e. their pre-edge values
   always @(posedge clock) begin : result_monitor
      top_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status    = rsp_status;
         got.best_bid  = rsp_best_bid;
         got.bid_valid = rsp_bid_valid;
         got.best_ask  = rsp_best_ask;
         got.ask_valid = rsp_ask_valid;
         got.spread    = rsp_spread;
         got.mid_twice = rsp_mid_twice;
         got.bid_depth = rsp_bid_depth;
         got.ask_depth = rsp_ask_depth;
         got.bid_count = rsp_bid_count;
         got.ask_count = rsp_ask_count;
         board.check_word(got);
      end
   end

   // Watchdog: ends the run if no handshake completes for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Request side drivers
   // ---------------------------------------------------------------------------

   // Offer one word and hold it until taken. valid is left high so a following
   // word can go back to back; the only low drive is for a gap or a drain.
   task automatic send_word(logic cmd, logic side, logic [FIELD_W-1:0] price,
                            logic [FIELD_W-1:0] qty);
      int gap;
      gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_side     <= side;
      req_price    <= price;
      req_quantity <= qty;
      do @(posedge clock); while (req_stall);
      board.note_word(cmd, side, price, qty);
      words_sent++;
   endtask

   // Stop offering and wait for every owed result; the block is idle after this
   task automatic drain_book();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.top_expected.size() != 0);
   endtask

   // depth_levels write; only called with the block drained
   task automatic write_depth(logic [CFG_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_depth_levels <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.depth_levels = value;
      settings_used++;
   endtask

   // quantity: removes, full-scale, all-bit random and small lot counts
   function automatic logic [FIELD_W-1:0] pick_qty(bit allow_zero);
      int r;
      logic [FIELD_W-1:0] q;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 25) q = '0;
      else if (r < 32) q = FIELD_MAX;
      else if (r < 45) q = $urandom;
      else q = $urandom_range(1000, 1);
      if (q == 0 && !allow_zero) q = 1;
      return q;
   endfunction

   // Mixed traffic on both sides around a price pool of 48 ticks
   task automatic run_churn(logic [FIELD_W-1:0] base, int count);
      int k, r;
      logic [FIELD_W-1:0] p;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r == 0) begin
            send_word(plob_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom);
         end else begin
            if (r < 4) p = '0;
            else if (r < 9) p = $urandom;
            else p = base + $urandom_range(47, 0);
            send_word(CMD_UPDATE, 1'($urandom_range(0, 1)), p, pick_qty(1'b1));
         end
      end
   endtask

   // Fill one side past capacity with distinct prices in scrambled order,
   // then overwrite / remove a few levels of the full side
   task automatic run_ladder(logic [FIELD_W-1:0] base);
      logic s;
      int   m, r, n, k;
      s = 1'($urandom_range(0, 1));
      m = 6 * $urandom_range(0, 7) + ($urandom_range(0, 1) ? 1 : 5);   // coprime to 48
      r = $urandom_range(0, 47);
      n = $urandom_range(33, 40);
      if ($urandom_range(0, 1))
         send_word(plob_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom);
      for (k = 0; k < n; k++)
         send_word(CMD_UPDATE, s, base + FIELD_W'((r + k * m) % 48), pick_qty(1'b0));
      repeat ($urandom_range(2, 6))
         send_word(CMD_UPDATE, s, base + $urandom_range(47, 0), pick_qty(1'b1));
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [CFG_W-1:0]   depth_plan [8];
      logic [FIELD_W-1:0] base;
      int phase, directed_words, seq;

      depth_plan = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd31, 6'd2, 6'd33, 6'd16};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;

      // Directed words, reset depth of 5 in force
      send_word(plob_pkg::CMD_CLEAR, plob_pkg::SIDE_ASK, FIELD_MAX, FIELD_MAX);  // empty book
      send_word(CMD_UPDATE, SIDE_BID, 100, 10);
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 110, 20);
      send_word(CMD_UPDATE, SIDE_BID, 0, 5);                   // zero price rejected
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 0, 0);
      send_word(CMD_UPDATE, SIDE_BID, 105, 0);                 // remove of an absent level
      send_word(CMD_UPDATE, SIDE_BID, 100, FIELD_MAX);         // overwrite in place
      send_word(CMD_UPDATE, SIDE_BID, 101, 1);                 // new best bid
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 109, 3);       // new best ask
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, FIELD_MAX, FIELD_MAX);  // top of the ask table
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 1, 1);         // crossed book, negative spread
      send_word(CMD_UPDATE, SIDE_BID, FIELD_MAX, 7);           // most negative spread
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 1, 0);         // remove best ask
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, 110, 0);       // remove from the middle
      send_word(CMD_UPDATE, SIDE_BID, FIELD_MAX, 0);           // remove best bid
      send_word(plob_pkg::CMD_CLEAR, SIDE_BID, 0, 0);
      send_word(CMD_UPDATE, plob_pkg::SIDE_ASK, FIELD_MAX, FIELD_MAX);
      send_word(CMD_UPDATE, SIDE_BID, FIELD_MAX, FIELD_MAX);   // largest mid, zero spread
      send_word(CMD_UPDATE, SIDE_BID, 1, 1);
      send_word(plob_pkg::CMD_CLEAR, plob_pkg::SIDE_ASK, 0, FIELD_MAX);
      directed_words = words_sent;

      // Random phases, each with its own depth setting, price pool and idling
      phase = 0;
      while (words_sent < directed_words + RANDOM_WORDS) begin
         drain_book();
         write_depth(phase < 8 ? depth_plan[phase] : CFG_W'($urandom_range(0, 63)));

         case ($urandom_range(0, 3))
            0:       base = FIELD_MAX - 47;                        // pool at the top of range
            1:       base = $urandom_range(32'hFFFF_FFD0, 1);
            default: base = $urandom_range(100, 1);
         endcase

         if (words_sent >= directed_words + RANDOM_WORDS - 150) begin
            // closing stretch runs at full rate
            tx_idle = 1'b0;
            rx_idle = 1'b0;
         end else begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
         end

         if (phase == 2) begin
            // hold results off while words keep coming back to back
            tx_idle = 1'b0;
            rx_hold = HOLD_CYCLES;
            run_churn(base, 40);
            tx_idle = 1'b1;
         end

         for (seq = 0; seq < 4; seq++) begin
            if ($urandom_range(0, 4) < 2) run_ladder(base);
            else run_churn(base, 15);
         end
         phase++;
      end

      drain_book();
      repeat (40) @(posedge clock);   // nothing more may come out
      board.finish_check();

      $display("tb: %0d words checked under %0d depth settings: %0d clears, %0d zero-price",
               board.checked, settings_used, board.clears, board.rejects);
      $display("tb: rejects, %0d full-side drops, deepest side %0d levels, one long hold-off",
               board.drops, board.deepest);
      if (board.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
